@@ hdl/logical_to_physical_map_table_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the logical-to-physical map table
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LOGICAL_TO_PHYSICAL_MAP_TABLE_DEFINES_SVH
`define LOGICAL_TO_PHYSICAL_MAP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define L2PMT_ASSERT_IMP(label, clk, dis, a, c) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
        else $error("l2pmt same-cycle check failed");

// Next-cycle implication, disabled while dis is high.
`define L2PMT_ASSERT_NEXT(label, clk, dis, a, c) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
        else $error("l2pmt next-cycle check failed");

`endif

@@ hdl/l2pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// l2pmt_pkg
// Types and constants of the logical-to-physical map table.
// ----------------------------------------------------------------------------
package l2pmt_pkg;

    // Sizes of the map. All are powers of two.
    localparam int LOGICAL_ENTRIES = 65536;
    localparam int PHYSICAL_PAGES  = 16384;
    localparam int SUBPAGES        = 4;

    localparam int LOGICAL_ADDR_W  = $clog2(LOGICAL_ENTRIES);
    localparam int PHYS_ADDR_W     = 16;
    localparam int PAGE_W          = 14;
    localparam int SLOT_W          = 2;

    typedef enum logic [1:0] {
        KIND_LOOKUP   = 2'd0,
        KIND_TRIM     = 2'd1,
        KIND_HOST_WR  = 2'd2,
        KIND_GC_WR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_LOOKUP     = 2'd0,
        EV_TRIM       = 2'd1,
        EV_INVALIDATE = 2'd2,
        EV_VALIDATE   = 2'd3
    } event_t;

    typedef struct packed {
        kind_t                    kind;
        logic [15:0]              logical_address;
        logic [PAGE_W-1:0]        page_number;
        logic [SLOT_W-1:0]        slot;
    } l2pmt_in_t;

    typedef struct packed {
        event_t                   event_res;
        logic [PHYS_ADDR_W-1:0]   physical_address;
        logic                     hit;
        logic                     last;
    } l2pmt_out_t;

    // One map entry: mapped flag and physical sub-page address.
    typedef struct packed {
        logic                     mapped;
        logic [PHYS_ADDR_W-1:0]   phys;
    } map_entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

endpackage

@@ hdl/logical_to_physical_map_table.sv @@
// ----------------------------------------------------------------------------
// logical_to_physical_map_table
// Page-level flash translation map with lookup, trim and write operations.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_data) carries one request per
// transaction: a lookup, a trim, a host write or a garbage-collection write
// on one logical sub-page address. The result channel (m_valid, m_ready,
// m_data) returns one or two transactions per request, the final one marked
// by last. A host write or trim of a mapped address first reports the old
// physical sub-page as an invalidate event.
// Results: a request is accepted while s_ready is high; its map entry is
// read on the accepting edge and registered, and in the execute state its
// results are written to the output queue, which drives m_data. The entry
// is written back in that execute state, and the next request is taken
// only after it, as long as results drain.
// Reset: after aresetn is released the block sweeps the whole map memory,
// one entry per cycle, marking every entry unmapped. The sweep covers all
// LOGICAL_ENTRIES (65536) entries, and s_ready stays low until it ends.
// Stalls: results wait in a four-entry output queue. While m_ready is low
// the block keeps taking requests until the queue could not hold two more
// results, then drops s_ready until the receiver catches up.
// ----------------------------------------------------------------------------
module logical_to_physical_map_table (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  l2pmt_pkg::l2pmt_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output l2pmt_pkg::l2pmt_out_t  m_data
);
    import l2pmt_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Map memory: one synchronous single-port array, flag and address
    // kept together so that the reset sweep clears both at once.
    map_entry_t map_mem [LOGICAL_ENTRIES];

    state_t                    state_reg, state_next;
    logic [LOGICAL_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    l2pmt_in_t                 item_reg;
    map_entry_t                rd_data_reg;

    l2pmt_out_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         count_reg, count_next;

    logic                      s_accept;
    logic                      m_accept;
    logic                      mem_we;
    logic [LOGICAL_ADDR_W-1:0] mem_waddr;
    map_entry_t                mem_wdata;
    logic [LOGICAL_ADDR_W-1:0] item_index;
    logic [1:0]                push_n;
    l2pmt_out_t                res0, res1;

    logic [PAGE_W-1:0]         page_wrap;
    logic [SLOT_W-1:0]         slot_wrap;
    logic [PHYS_ADDR_W-1:0]    fresh_phys;
    logic [PHYS_ADDR_W-1:0]    old_phys;
    logic                      was_mapped;

    // A request is taken only when the queue can absorb two more results,
    // which is all one request can produce.
    assign s_ready  = (state_reg == ST_IDLE) && (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = queue_reg[rd_ptr_reg];
    assign m_accept = m_valid && m_ready;

    // Address and page arithmetic of the item under execution. The sizes
    // are powers of two, so the wraps are plain masks.
    assign item_index = LOGICAL_ADDR_W'(32'(item_reg.logical_address) % LOGICAL_ENTRIES);
    assign page_wrap  = PAGE_W'(32'(item_reg.page_number) % PHYSICAL_PAGES);
    assign slot_wrap  = SLOT_W'(32'(item_reg.slot) % SUBPAGES);
    assign fresh_phys = PHYS_ADDR_W'(32'(page_wrap) * SUBPAGES + 32'(slot_wrap));
    assign was_mapped = rd_data_reg.mapped;
    assign old_phys   = rd_data_reg.mapped ? rd_data_reg.phys : '0;

    // Memory: the read is issued on the accepting edge, its data is
    // registered and used in the execute cycle, where the write-back
    // happens. Requests never overlap, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_data_reg <= map_mem[LOGICAL_ADDR_W'(32'(s_data.logical_address)
                                                   % LOGICAL_ENTRIES)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    // Next state, memory write and result generation.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = item_index;
        mem_wdata     = '{mapped: 1'b1, phys: fresh_phys};
        push_n        = 2'd0;
        res0          = '{event_res: EV_LOOKUP, physical_address: old_phys,
                          hit: was_mapped, last: 1'b1};
        res1          = res0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + LOGICAL_ADDR_W'(1);
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                case (item_reg.kind)
                    KIND_LOOKUP: begin
                        push_n = 2'd1;
                    end
                    KIND_TRIM: begin
                        mem_we    = 1'b1;
                        mem_wdata = '{mapped: 1'b0, phys: rd_data_reg.phys};
                        if (was_mapped) begin
                            push_n = 2'd2;
                            res0   = '{event_res: EV_INVALIDATE, physical_address: old_phys,
                                       hit: 1'b1, last: 1'b0};
                            res1   = '{event_res: EV_TRIM, physical_address: old_phys,
                                       hit: 1'b1, last: 1'b1};
                        end else begin
                            push_n = 2'd1;
                            res0   = '{event_res: EV_TRIM, physical_address: '0,
                                       hit: 1'b0, last: 1'b1};
                        end
                    end
                    KIND_HOST_WR: begin
                        mem_we = 1'b1;
                        if (was_mapped) begin
                            push_n = 2'd2;
                            res0   = '{event_res: EV_INVALIDATE, physical_address: old_phys,
                                       hit: 1'b1, last: 1'b0};
                            res1   = '{event_res: EV_VALIDATE, physical_address: fresh_phys,
                                       hit: 1'b1, last: 1'b1};
                        end else begin
                            push_n = 2'd1;
                            res0   = '{event_res: EV_VALIDATE, physical_address: fresh_phys,
                                       hit: 1'b0, last: 1'b1};
                        end
                    end
                    KIND_GC_WR: begin
                        // The old mapping is overwritten without a report.
                        mem_we = 1'b1;
                        push_n = 2'd1;
                        res0   = '{event_res: EV_VALIDATE, physical_address: fresh_phys,
                                   hit: was_mapped, last: 1'b1};
                    end
                    default: begin
                        push_n = 2'd0;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output queue pointers.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(m_accept);
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(m_accept);
    end

endmodule

@@ hdl/l2pmt_checker.sv @@
// ----------------------------------------------------------------------------
// l2pmt_checker
// Port-level assertions for the logical-to-physical map table.
// ----------------------------------------------------------------------------
`include "logical_to_physical_map_table_defines.svh"

module l2pmt_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  l2pmt_pkg::l2pmt_in_t   s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  l2pmt_pkg::l2pmt_out_t  m_data
);
    import l2pmt_pkg::*;

    logic s_accept;

    assign s_accept = s_valid && s_ready;

    // A stalled result stays in place.
    `L2PMT_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_valid && !m_ready,
                       m_valid && $stable(m_data))

    // Reset starts the clearing sweep, so no request is taken next cycle.
    `L2PMT_ASSERT_NEXT(a_reset_blocks_input, aclk, 1'b0, !aresetn, !s_ready)

    // Each request occupies the map through its execute state, with s_ready low.
    `L2PMT_ASSERT_NEXT(a_no_back_to_back, aclk, !aresetn, s_accept, !s_ready)

    // Every request has a result in the output queue once it has executed.
    `L2PMT_ASSERT_IMP(a_result_follows, aclk, !aresetn, $past(s_accept, 2) && $past(aresetn),
                      m_valid)

    // A request on the input must carry a known kind.
    `L2PMT_ASSERT_IMP(a_kind_known, aclk, !aresetn, s_valid,
                      !$isunknown(s_data.kind))

endmodule

bind logical_to_physical_map_table l2pmt_checker u_l2pmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the logical-to-physical map table
// A short directed pass followed by about eleven hundred random requests.
// Each accepted request is run through a behavioral copy of the translation
// map, and every result transaction is checked in order against it or against
// results written out by hand. Both channels idle at random, and the result
// side twice holds off long enough to back the block up into its request port.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import l2pmt_pkg::*;

    // Size of the random part of the run. The directed rows come on top.
    localparam int RANDOM_ITEMS = 1130;
    // Pool of logical addresses that most random requests reuse, so that
    // lookups, trims and rewrites keep landing on mapped entries.
    localparam int HOT_COUNT    = 24;
    // Cycles to wait after the last result has come back before the verdict.
    localparam int TAIL_CYCLES  = 16;
    // First mismatches printed in full; later ones are only counted.
    localparam int REPORT_LIMIT = 10;

    // One request to send, with optionally its results written out by hand.
    // When typed_count is zero the results come from the behavioral map.
    typedef struct {
        l2pmt_in_t  item;
        int         typed_count;
        l2pmt_out_t first;
        l2pmt_out_t second;
    } plan_row_t;

    // Clock and the block's inputs, all known from time zero.
    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    l2pmt_in_t  s_data  = '0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    l2pmt_out_t m_data;

    // Behavioral copy of the map: flag and physical sub-page per entry.
    bit                     entry_mapped [LOGICAL_ENTRIES];
    bit [PHYS_ADDR_W-1:0]   entry_phys   [LOGICAL_ENTRIES];

    // Requests that are on the input port, oldest first, and the results
    // that the block still owes, oldest first.
    plan_row_t  offered_rows[$];
    l2pmt_out_t pending_results[$];

    int unsigned fault_count = 0;

    // Traffic shaping shared between the request and result sides.
    bit quiet       = 1'b0;
    bit squeeze_req = 1'b0;

    always #5 aclk = ~aclk;

    logical_to_physical_map_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    function automatic l2pmt_out_t outcome(event_t ev, logic [PHYS_ADDR_W-1:0] pa,
                                           logic hit, logic last);
        l2pmt_out_t r;
        r.event_res        = ev;
        r.physical_address = pa;
        r.hit              = hit;
        r.last             = last;
        return r;
    endfunction

    function automatic plan_row_t plan_row(kind_t kind, logic [15:0] la,
                                           logic [PAGE_W-1:0] page, logic [SLOT_W-1:0] slot,
                                           int typed_count, l2pmt_out_t first,
                                           l2pmt_out_t second);
        plan_row_t row;
        row.item.kind            = kind;
        row.item.logical_address = la;
        row.item.page_number     = page;
        row.item.slot            = slot;
        row.typed_count          = typed_count;
        row.first                = first;
        row.second               = second;
        return row;
    endfunction

    // Applies one request to the behavioral map and returns how many result
    // transactions it causes (one or two), the results in order in r0, r1.
    function automatic int translate_request(l2pmt_in_t item, output l2pmt_out_t r0,
                                             output l2pmt_out_t r1);
        logic [15:0]            la;
        logic                   was_mapped;
        logic [PHYS_ADDR_W-1:0] old_phys;
        logic [PHYS_ADDR_W-1:0] new_phys;
        int                     count;
        la         = item.logical_address;
        was_mapped = entry_mapped[la];
        old_phys   = was_mapped ? entry_phys[la] : '0;
        // The new sub-page is page * SUBPAGES + slot, kept in the address width.
        new_phys   = PHYS_ADDR_W'(item.page_number * SUBPAGES + item.slot);
        r0         = '0;
        r1         = '0;
        count      = 1;
        case (item.kind)
            KIND_LOOKUP: begin
                r0 = outcome(EV_LOOKUP, old_phys, was_mapped, 1'b1);
            end
            KIND_TRIM: begin
                if (was_mapped) begin
                    r0    = outcome(EV_INVALIDATE, old_phys, 1'b1, 1'b0);
                    r1    = outcome(EV_TRIM, old_phys, 1'b1, 1'b1);
                    count = 2;
                    entry_mapped[la] = 1'b0;
                end else begin
                    r0 = outcome(EV_TRIM, '0, 1'b0, 1'b1);
                end
            end
            default: begin
                // Only a host write reports the sub-page it replaces; a
                // garbage-collection write overwrites it silently.
                if (item.kind == KIND_HOST_WR && was_mapped) begin
                    r0    = outcome(EV_INVALIDATE, old_phys, 1'b1, 1'b0);
                    r1    = outcome(EV_VALIDATE, new_phys, 1'b1, 1'b1);
                    count = 2;
                end else begin
                    r0 = outcome(EV_VALIDATE, new_phys, was_mapped, 1'b1);
                end
                entry_phys[la]   = new_phys;
                entry_mapped[la] = 1'b1;
            end
        endcase
        return count;
    endfunction

    // Puts one request on the input port and returns once it has been
    // accepted. A random number of idle cycles may come first, except
    // during the quiet stretch. The valid line is only lowered when a gap
    // really follows, so it never drops and rises within one edge.
    task automatic offer(plan_row_t row);
        int gap = 0;
        while (!quiet && $urandom_range(0, 99) < 38) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        offered_rows.push_back(row);
        s_valid <= 1'b1;
        s_data  <= row.item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Every request accepted at this edge is run through the behavioral map
    // right away, so the expected results queue up in acceptance order. For
    // directed rows with results written out by hand those results are
    // expected instead, while the map is still updated.
    always @(posedge aclk) begin : predict_on_accept
        plan_row_t  row;
        l2pmt_out_t r0;
        l2pmt_out_t r1;
        int         count;
        if (aresetn && s_valid && s_ready) begin
            row   = offered_rows.pop_front();
            count = translate_request(s_data, r0, r1);
            if (row.typed_count != 0) begin
                count = row.typed_count;
                r0    = row.first;
                r1    = row.second;
            end
            pending_results.push_back(r0);
            if (count == 2) pending_results.push_back(r1);
        end
    end

    // Every result transaction is checked against the oldest expected one,
    // field by field. Values are sampled as they stood just before the edge.
    always @(posedge aclk) begin : check_results
        l2pmt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("tb: result with nothing pending: ev=%0d pa=%h hit=%b last=%b",
                             m_data.event_res, m_data.physical_address,
                             m_data.hit, m_data.last);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.event_res !== want.event_res
                        || m_data.physical_address !== want.physical_address
                        || m_data.hit !== want.hit || m_data.last !== want.last) begin
                    if (fault_count < REPORT_LIMIT) begin
                        $display("tb: mismatch at %0t: expected ev=%0d pa=%h hit=%b last=%b,",
                                 $realtime, want.event_res, want.physical_address,
                                 want.hit, want.last);
                        $display("    got ev=%0d pa=%h hit=%b last=%b",
                                 m_data.event_res, m_data.physical_address,
                                 m_data.hit, m_data.last);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Result side. Ready is redrawn every cycle, held high through the quiet
    // stretch, and held low for a long hold-off whenever the request side
    // asks for one, so the block's output queue fills and s_ready drops.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = 200 + $urandom_range(0, 100);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // Request side: reset, the directed rows, the random part, then the
    // drain and the verdict.
    initial begin : request_side
        plan_row_t              directed[$];
        logic [15:0]            hot_addr [HOT_COUNT];
        kind_t                  kind;
        logic [15:0]            la;
        int                     pick;

        hot_addr[0] = 16'h0000;
        hot_addr[1] = 16'hFFFF;
        for (int i = 2; i < HOT_COUNT; i++) hot_addr[i] = 16'($urandom);

        // Directed rows. Results are spelled out where they follow directly
        // from the state: misses on a cleared map, first writes at the address
        // extremes, lookups and trims of entries just written or trimmed, a host
        // write over a mapped entry, and a trim of an entry mapped to physical
        // sub-page zero, which still hits. Remaining rows rely on the behavioral map.
        directed.push_back(plan_row(KIND_LOOKUP, 16'h0000, 14'h0000, 2'd0, 1,
                                    outcome(EV_LOOKUP, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'hFFFF, 14'h3FFF, 2'd3, 1,
                                    outcome(EV_LOOKUP, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_TRIM, 16'h1234, 14'h0000, 2'd0, 1,
                                    outcome(EV_TRIM, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'h0000, 14'h0000, 2'd0, 1,
                                    outcome(EV_VALIDATE, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'hFFFF, 14'h3FFF, 2'd3, 1,
                                    outcome(EV_VALIDATE, 16'hFFFF, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'h0000, 14'h0000, 2'd0, 1,
                                    outcome(EV_LOOKUP, 16'h0000, 1'b1, 1'b1), '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'hFFFF, 14'h0000, 2'd0, 1,
                                    outcome(EV_LOOKUP, 16'hFFFF, 1'b1, 1'b1), '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'hFFFF, 14'h1555, 2'd2, 2,
                                    outcome(EV_INVALIDATE, 16'hFFFF, 1'b1, 1'b0),
                                    outcome(EV_VALIDATE, 16'h5556, 1'b1, 1'b1)));
        directed.push_back(plan_row(KIND_GC_WR, 16'hFFFF, 14'h2AAA, 2'd1, 0, '0, '0));
        directed.push_back(plan_row(KIND_GC_WR, 16'h8000, 14'h3FFF, 2'd0, 0, '0, '0));
        directed.push_back(plan_row(KIND_TRIM, 16'h8000, 14'h0000, 2'd0, 0, '0, '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'h8000, 14'h0000, 2'd0, 1,
                                    outcome(EV_LOOKUP, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_TRIM, 16'h8000, 14'h0000, 2'd0, 1,
                                    outcome(EV_TRIM, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_TRIM, 16'h0000, 14'h3FFF, 2'd3, 2,
                                    outcome(EV_INVALIDATE, 16'h0000, 1'b1, 1'b0),
                                    outcome(EV_TRIM, 16'h0000, 1'b1, 1'b1)));
        directed.push_back(plan_row(KIND_LOOKUP, 16'h0000, 14'h0000, 2'd0, 1,
                                    outcome(EV_LOOKUP, 16'h0000, 1'b0, 1'b1), '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'h5555, 14'h2AAA, 2'd1, 0, '0, '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'h5555, 14'h1555, 2'd2, 0, '0, '0));
        directed.push_back(plan_row(KIND_GC_WR, 16'h5555, 14'h0000, 2'd3, 0, '0, '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'h5555, 14'h0000, 2'd0, 0, '0, '0));
        directed.push_back(plan_row(KIND_HOST_WR, 16'hAAAA, 14'h3FFF, 2'd3, 0, '0, '0));
        directed.push_back(plan_row(KIND_GC_WR, 16'hAAAA, 14'h0000, 2'd0, 0, '0, '0));
        directed.push_back(plan_row(KIND_TRIM, 16'hAAAA, 14'h0000, 2'd0, 0, '0, '0));
        directed.push_back(plan_row(KIND_LOOKUP, 16'hFFFF, 14'h0000, 2'd0, 0, '0, '0));

        // Reset is held low at the start, then released. Afterwards the block
        // sweeps its whole map with s_ready low; the first request simply waits on it.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) offer(directed[i]);

        // Random part. Most requests hit a small pool of addresses so that
        // rewrites, trims of mapped entries and lookup hits are common; the
        // rest spread over the full address range. Page and slot are always
        // drawn over their full widths.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 500 && i < 650);
            if (i == 300 || i == 800) squeeze_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = KIND_LOOKUP;
            else if (pick < 50) kind = KIND_TRIM;
            else if (pick < 80) kind = KIND_HOST_WR;
            else                kind = KIND_GC_WR;
            if ($urandom_range(0, 99) < 80) la = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
            else                            la = 16'($urandom);
            offer(plan_row(kind, la, PAGE_W'($urandom), SLOT_W'($urandom), 0, '0, '0));
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait until every expected result has been seen, then a few
        // more cycles so that any surplus transaction is caught.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog. Ends the run as a failure if it hangs, well after a correct run
    // would have finished its sweep after reset and all of its traffic.
    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/l2pmt_pkg.sv
hdl/logical_to_physical_map_table.sv
hdl/l2pmt_checker.sv
bench/tb.sv
